@@ hdl/run_grouped_min_max_mean_core_assert.svh @@
// Assertion macros for the grouped min/max/mean core.
// Both expect signals named clock and reset in the scope of use.
`ifndef RUN_GROUPED_MIN_MAX_MEAN_CORE_ASSERT_SVH
`define RUN_GROUPED_MIN_MAX_MEAN_CORE_ASSERT_SVH

// Same-cycle implication.
`define RGMM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RGMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/rgmm_pkg.sv @@
`timescale 1ns / 1ps
package rgmm_pkg;

   localparam int unsigned TEMP_W      = 8;
   localparam int unsigned SUM_W       = 28;
   localparam int unsigned CNT_W       = 21;
   localparam int unsigned LINE_W      = 20;
   localparam int unsigned YEAR_W      = 16;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned MAX_RECORDS = 1048576;

   typedef logic signed [TEMP_W-1:0] temp_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   localparam cnt_type  CNT_LIMIT  = CNT_W'(MAX_RECORDS);
   localparam temp_type LOW_RESET  = -8'sd99;
   localparam temp_type HIGH_RESET = 8'sd99;
   localparam logic [3:0] MONTH_MAX  = 4'd12;
   localparam logic [4:0] HOUR_MAX   = 5'd23;
   localparam logic [5:0] MINUTE_MAX = 6'd59;

   // result kinds
   localparam logic [1:0] KIND_RUN  = 2'd0;
   localparam logic [1:0] KIND_YEAR = 2'd1;
   localparam logic [1:0] KIND_BAD  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH = 1'b1;

   // divider source
   localparam logic SEL_RUN = 1'b0;
   localparam logic SEL_ALL = 1'b1;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [3:0]        month;
      logic [4:0]        day;
      logic [4:0]        hour;
      logic [5:0]        minute;
      temp_type          temperature;
      logic              last_item;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [YEAR_W-1:0] year_out;
      logic [3:0]        month_out;
      temp_type          minimum;
      temp_type          maximum;
      temp_type          average;
      cnt_type           count;
      logic [LINE_W-1:0] line_number;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       upd;
      logic       clear;
      logic       div_start;
      logic       div_sel;
      logic       out_load;
      logic [1:0] out_kind;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic rec_ok;
      logic run_active;
      logic month_change;
      logic last_item;
      logic div_done;
   } status_type;

endpackage

@@ hdl/rgmm_dp.sv @@
`timescale 1ns / 1ps
module rgmm_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  rgmm_pkg::req_type                 req_data,
   output rgmm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rgmm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rgmm_pkg::TEMP_W-1:0]       csr_data,
   input  rgmm_pkg::cmd_type                 cmd,
   output rgmm_pkg::status_type              status
);
   import rgmm_pkg::*;

   localparam int unsigned STEP_W = $clog2(TEMP_W);

   temp_type low_ff, low_in, high_ff, high_in;
   req_type  item_ff, item_in;
   logic [LINE_W-1:0] line_ff, line_in, line_cnt_ff, line_cnt_in;
   logic              run_active_ff, run_active_in;
   logic [3:0]        run_month_ff, run_month_in;
   temp_type          run_min_ff, run_min_in, run_max_ff, run_max_in;
   sum_type           run_sum_ff, run_sum_in;
   cnt_type           run_cnt_ff, run_cnt_in;
   temp_type          all_min_ff, all_min_in, all_max_ff, all_max_in;
   sum_type           all_sum_ff, all_sum_in;
   cnt_type           all_cnt_ff, all_cnt_in;
   logic [YEAR_W-1:0] year_ff, year_in;

   // restoring divider, one quotient bit per cycle
   logic [SUM_W-1:0]  rem_ff, rem_in;
   cnt_type           den_ff, den_in;
   logic [TEMP_W-1:0] q_ff, q_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic              neg_ff, neg_in, zero_ff, zero_in;
   logic [SUM_W:0]    trial;
   sum_type           src_sum;
   cnt_type           src_cnt;
   temp_type          avg_val;

   rsp_type rsp_ff, rsp_in;
   temp_type temp;
   logic new_run;

   assign temp      = item_ff.temperature;
   assign new_run   = !run_active_ff || (run_month_ff != item_ff.month);
   assign csr_ready = 1'b1;
   assign rsp_data  = rsp_ff;

   // day needs no upper check: 5 bits cannot exceed 31
   assign status.rec_ok = (item_ff.month != 4'd0) && (item_ff.month <= MONTH_MAX) &&
                          (item_ff.day != 5'd0) && (item_ff.hour <= HOUR_MAX) &&
                          (item_ff.minute <= MINUTE_MAX) &&
                          (temp >= low_ff) && (temp <= high_ff);
   assign status.run_active   = run_active_ff;
   assign status.month_change = run_month_ff != item_ff.month;
   assign status.last_item    = item_ff.last_item;
   assign status.div_done     = done_ff;

   assign src_sum = (cmd.div_sel == SEL_ALL) ? all_sum_ff : run_sum_ff;
   assign src_cnt = (cmd.div_sel == SEL_ALL) ? all_cnt_ff : run_cnt_ff;
   assign trial   = {1'b0, rem_ff} - {1'b0, SUM_W'(den_ff) << step_ff};
   assign avg_val = zero_ff ? temp_type'(0) : (neg_ff ? temp_type'(-q_ff) : temp_type'(q_ff));

   always_comb begin
      low_in        = low_ff;
      high_in       = high_ff;
      item_in       = item_ff;
      line_in       = line_ff;
      line_cnt_in   = line_cnt_ff;
      run_active_in = run_active_ff;
      run_month_in  = run_month_ff;
      run_min_in    = run_min_ff;
      run_max_in    = run_max_ff;
      run_sum_in    = run_sum_ff;
      run_cnt_in    = run_cnt_ff;
      all_min_in    = all_min_ff;
      all_max_in    = all_max_ff;
      all_sum_in    = all_sum_ff;
      all_cnt_in    = all_cnt_ff;
      year_in       = year_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      q_in          = q_ff;
      step_in       = step_ff;
      busy_in       = busy_ff;
      done_in       = 1'b0;
      neg_in        = neg_ff;
      zero_in       = zero_ff;
      rsp_in        = rsp_ff;

      if (csr_valid) begin
         unique case (csr_index)
            REG_LOW:  low_in  = temp_type'(csr_data);
            REG_HIGH: high_in = temp_type'(csr_data);
         endcase
      end

      if (cmd.capture) begin
         item_in     = req_data;
         line_in     = line_cnt_ff;
         line_cnt_in = line_cnt_ff + LINE_W'(1);
      end

      if (cmd.upd) begin
         run_active_in = 1'b1;
         if (!run_active_ff) begin
            year_in    = item_ff.year;
            all_min_in = temp;
            all_max_in = temp;
         end else begin
            if (temp < all_min_ff) all_min_in = temp;
            if (temp > all_max_ff) all_max_in = temp;
         end
         if (new_run) begin
            run_month_in = item_ff.month;
            run_min_in   = temp;
            run_max_in   = temp;
            run_sum_in   = SUM_W'(temp);
            run_cnt_in   = CNT_W'(1);
         end else begin
            if (temp < run_min_ff) run_min_in = temp;
            if (temp > run_max_ff) run_max_in = temp;
            if (run_cnt_ff < CNT_LIMIT) begin
               run_cnt_in = run_cnt_ff + CNT_W'(1);
               run_sum_in = run_sum_ff + SUM_W'(temp);
            end
         end
         if (all_cnt_ff < CNT_LIMIT) begin
            all_cnt_in = all_cnt_ff + CNT_W'(1);
            all_sum_in = all_sum_ff + SUM_W'(temp);
         end
      end

      if (cmd.clear) begin
         line_cnt_in   = '0;
         run_active_in = 1'b0;
         run_month_in  = '0;
         run_min_in    = '0;
         run_max_in    = '0;
         run_sum_in    = '0;
         run_cnt_in    = '0;
         all_min_in    = '0;
         all_max_in    = '0;
         all_sum_in    = '0;
         all_cnt_in    = '0;
         year_in       = '0;
      end

      // |sum| <= 128 * count, so eight quotient bits suffice
      if (cmd.div_start) begin
         neg_in  = src_sum[SUM_W-1];
         rem_in  = src_sum[SUM_W-1] ? SUM_W'(-src_sum) : SUM_W'(src_sum);
         den_in  = src_cnt;
         zero_in = (src_cnt == '0);
         q_in    = '0;
         step_in = STEP_W'(TEMP_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[SUM_W]) begin
            rem_in = trial[SUM_W-1:0];
            q_in   = q_ff | (TEMP_W'(1) << step_ff);
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end

      if (cmd.out_load) begin
         rsp_in             = '0;
         rsp_in.kind        = cmd.out_kind;
         rsp_in.last_result = cmd.out_last;
         unique case (cmd.out_kind)
            KIND_BAD: rsp_in.line_number = line_ff;
            KIND_RUN: begin
               rsp_in.year_out  = year_ff;
               rsp_in.month_out = run_month_ff;
               rsp_in.minimum   = run_min_ff;
               rsp_in.maximum   = run_max_ff;
               rsp_in.average   = avg_val;
               rsp_in.count     = run_cnt_ff;
            end
            KIND_YEAR: begin
               rsp_in.year_out  = year_ff;
               rsp_in.minimum   = all_min_ff;
               rsp_in.maximum   = all_max_ff;
               rsp_in.average   = avg_val;
               rsp_in.count     = all_cnt_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff        <= LOW_RESET;
         high_ff       <= HIGH_RESET;
         line_cnt_ff   <= '0;
         run_active_ff <= 1'b0;
         run_month_ff  <= '0;
         run_min_ff    <= '0;
         run_max_ff    <= '0;
         run_sum_ff    <= '0;
         run_cnt_ff    <= '0;
         all_min_ff    <= '0;
         all_max_ff    <= '0;
         all_sum_ff    <= '0;
         all_cnt_ff    <= '0;
         year_ff       <= '0;
         busy_ff       <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         low_ff        <= low_in;
         high_ff       <= high_in;
         line_cnt_ff   <= line_cnt_in;
         run_active_ff <= run_active_in;
         run_month_ff  <= run_month_in;
         run_min_ff    <= run_min_in;
         run_max_ff    <= run_max_in;
         run_sum_ff    <= run_sum_in;
         run_cnt_ff    <= run_cnt_in;
         all_min_ff    <= all_min_in;
         all_max_ff    <= all_max_in;
         all_sum_ff    <= all_sum_in;
         all_cnt_ff    <= all_cnt_in;
         year_ff       <= year_in;
         busy_ff       <= busy_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      line_ff <= line_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      rsp_ff  <= rsp_in;
   end

endmodule

@@ hdl/rgmm_ctrl.sv @@
`timescale 1ns / 1ps
module rgmm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rgmm_pkg::status_type status,
   output rgmm_pkg::cmd_type    cmd
);
   import rgmm_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CHECK   = 4'd1;
   localparam logic [3:0] ST_BAD_OUT = 4'd2;
   localparam logic [3:0] ST_OLD_DIV = 4'd3;
   localparam logic [3:0] ST_OLD_OUT = 4'd4;
   localparam logic [3:0] ST_UPDATE  = 4'd5;
   localparam logic [3:0] ST_END     = 4'd6;
   localparam logic [3:0] ST_RUN_DIV = 4'd7;
   localparam logic [3:0] ST_RUN_OUT = 4'd8;
   localparam logic [3:0] ST_ALL_DIV = 4'd9;
   localparam logic [3:0] ST_ALL_OUT = 4'd10;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_BAD_OUT) || (state_ff == ST_OLD_OUT) ||
                      (state_ff == ST_RUN_OUT) || (state_ff == ST_ALL_OUT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.rec_ok) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_BAD;
               cmd.out_last = !status.last_item;
               state_in     = ST_BAD_OUT;
            end else if (status.run_active && status.month_change) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = SEL_RUN;
               state_in      = ST_OLD_DIV;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_BAD_OUT: begin
            if (!rsp_stall) state_in = status.last_item ? ST_END : ST_IDLE;
         end
         ST_OLD_DIV: begin
            if (status.div_done) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_RUN;
               cmd.out_last = !status.last_item;
               state_in     = ST_OLD_OUT;
            end
         end
         ST_OLD_OUT: begin
            if (!rsp_stall) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.upd  = 1'b1;
            state_in = status.last_item ? ST_END : ST_IDLE;
         end
         ST_END: begin
            cmd.div_start = 1'b1;
            if (status.run_active) begin
               cmd.div_sel = SEL_RUN;
               state_in    = ST_RUN_DIV;
            end else begin
               cmd.div_sel = SEL_ALL;
               state_in    = ST_ALL_DIV;
            end
         end
         ST_RUN_DIV: begin
            if (status.div_done) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_RUN;
               state_in     = ST_RUN_OUT;
            end
         end
         ST_RUN_OUT: begin
            if (!rsp_stall) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = SEL_ALL;
               state_in      = ST_ALL_DIV;
            end
         end
         ST_ALL_DIV: begin
            if (status.div_done) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_YEAR;
               cmd.out_last = 1'b1;
               state_in     = ST_ALL_OUT;
            end
         end
         ST_ALL_OUT: begin
            if (!rsp_stall) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/run_grouped_min_max_mean_core.sv @@
// Grouped temperature statistics. Records come in one beat at a time on req_;
// each is range checked (month, day, hour, minute, and temperature against the
// two limit registers) and a bad record gives a kind-2 result with its line
// number. Good records are grouped into runs of equal month; a month change
// emits the closed run (min, max, truncating mean, count), and a beat with
// last_item emits the open run and then the whole-stream totals, after which
// all statistics and the line count start over. One record is in work at a
// time: a good record that closes nothing passes through check and update, a
// bad one through check and then waits for its result to be taken, and each
// emitted group waits on the shared 8-step restoring divider that forms the
// mean. Limit registers (index 0 low, 1 high) are written through csr_, which
// is always ready; writes belong in idle periods.
`timescale 1ns / 1ps
module run_grouped_min_max_mean_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rgmm_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rgmm_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rgmm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rgmm_pkg::TEMP_W-1:0]     csr_data
);
   import rgmm_pkg::*;

   // command/status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: one record per pass, result beats held in rsp_ until taken
   rgmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: checks, run/stream accumulators, divider, result register
   rgmm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

@@ hdl/rgmm_checker.sv @@
`timescale 1ns / 1ps
`include "run_grouped_min_max_mean_core_assert.svh"
module rgmm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input rgmm_pkg::rsp_type               rsp_data
);
   import rgmm_pkg::*;

   logic req_beat, rsp_held;
   logic bad_beat, bad_clean, year_beat, year_clean;

   assign req_beat   = req_valid && !req_stall;
   assign rsp_held   = rsp_valid && rsp_stall;
   assign bad_beat   = rsp_valid && (rsp_data.kind == KIND_BAD);
   assign bad_clean  = (rsp_data.count == '0) && (rsp_data.year_out == '0) &&
                       (rsp_data.month_out == '0);
   assign year_beat  = rsp_valid && (rsp_data.kind == KIND_YEAR);
   assign year_clean = rsp_data.last_result && (rsp_data.month_out == '0);

   // held result beat stays put
   `RGMM_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_data), "held beat changed")
   // no new record while a result beat is pending
   `RGMM_ASSERT_SAME(a_no_overlap, rsp_valid, req_stall, "input open while result pending")
   // a record is checked before any result can show
   `RGMM_ASSERT_NEXT(a_check_gap, req_beat, !rsp_valid, "result right after input beat")
   // bad-record beats carry no count, year or month
   `RGMM_ASSERT_SAME(a_bad_zero, bad_beat, bad_clean, "bad record carries stats")
   // stream totals always close out the input
   `RGMM_ASSERT_SAME(a_year_last, year_beat, year_clean, "year result not last")

endmodule

bind run_grouped_min_max_mean_core rgmm_checker u_rgmm_checker (.*);
